>>> src/modexp_pkg.sv
// Shared constants, types and helpers for the modular exponentiation block.
package modexp_pkg;

	localparam int unsigned BASE_BITS = 64;
	localparam int unsigned EXP_BITS  = 64;
	localparam int unsigned MOD_BITS  = 32;

	localparam int unsigned IN_FIELD_BITS = BASE_BITS + EXP_BITS + MOD_BITS + 1;
	localparam int unsigned IN_TDATA_W    = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W   = ((MOD_BITS + 7) / 8) * 8;

	localparam int unsigned BASE_LSB = 0;
	localparam int unsigned EXP_LSB  = BASE_BITS;
	localparam int unsigned MOD_LSB  = BASE_BITS + EXP_BITS;

	localparam int unsigned CNT_W = $clog2(BASE_BITS > MOD_BITS ? BASE_BITS : MOD_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PREP,
		ST_MUL,
		ST_FINISH
	} state_t;

	// t < 3m: bring it into 0..m-1
	function automatic logic [MOD_BITS-1:0] mod_fold(
		input logic [MOD_BITS+1:0] t,
		input logic [MOD_BITS-1:0] m
	);
		logic [MOD_BITS+1:0] m1;
		logic [MOD_BITS+1:0] m2;
		logic [MOD_BITS+1:0] r;
		begin
			m1 = {2'b00, m};
			m2 = {1'b0, m, 1'b0};
			if (t >= m2) begin
				r = t - m2;
			end else if (t >= m1) begin
				r = t - m1;
			end else begin
				r = t;
			end
			return r[MOD_BITS-1:0];
		end
	endfunction

endpackage

>>> src/modular_exponentiation.sv
// Top level: bit-serial modular exponentiation by right-to-left square-and-multiply.
//
// Each item carries base, exponent and modulus; one result item follows per input item.
// The base magnitude is reduced one bit per cycle, the PREP state fixes the sign, then
// for each exponent bit up to the highest set one two shift-and-add modular multipliers
// form acc*sq and sq*sq side by side. Invalid items and a modulus of one go straight to
// the finish state. One item is worked on at a time; the result register lets the next
// item in while it waits.
module modular_exponentiation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// base_value[63:0], exponent[127:64], modulus[160:128], zero fill
	input  logic [modexp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// power_residue[31:0]
	output logic [modexp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// invalid[0]
	output logic                                 m_axis_tuser
);

	localparam int unsigned MB = modexp_pkg::MOD_BITS;
	localparam int unsigned BB = modexp_pkg::BASE_BITS;
	localparam int unsigned EB = modexp_pkg::EXP_BITS;
	localparam int unsigned CW = modexp_pkg::CNT_W;
	localparam int unsigned OW = modexp_pkg::OUT_TDATA_W;

	modexp_pkg::state_t state_q, state_d;

	logic [MB-1:0]   mod_q;
	logic [BB-1:0]   bmag_q;
	logic            bneg_q;
	logic [EB-1:0]   exp_q;
	logic [MB-1:0]   red_q;
	logic [MB-1:0]   acc_q;
	logic [MB-1:0]   sq_q;
	logic [MB-1:0]   mplr_q;
	logic [MB-1:0]   ra_q;
	logic [MB-1:0]   rs_q;
	logic [CW-1:0]   cnt_q;
	logic            inv_q;
	logic            out_valid_q;
	logic [MB-1:0]   out_res_q;
	logic            out_inv_q;

	logic [BB-1:0]   in_base;
	logic [EB-1:0]   in_exp;
	logic [MB:0]     in_mod;
	logic            in_bad;
	logic            in_trivial;
	logic            accept;
	logic            out_load;
	logic            out_free;
	logic            red_last;
	logic            mul_last;
	logic            exp_done;
	logic [MB-1:0]   red_next;
	logic [MB-1:0]   ra_next;
	logic [MB-1:0]   rs_next;
	logic [MB-1:0]   sq_start;

	assign in_base = s_axis_tdata[modexp_pkg::BASE_LSB +: BB];
	assign in_exp  = s_axis_tdata[modexp_pkg::EXP_LSB +: EB];
	assign in_mod  = s_axis_tdata[modexp_pkg::MOD_LSB +: MB + 1];

	assign in_bad     = in_mod[MB] || (in_mod == '0) || in_exp[EB-1];
	assign in_trivial = in_bad || (in_mod == (MB + 1)'(1));

	assign out_free = !out_valid_q || m_axis_tready;
	assign red_last = cnt_q == CW'(BB - 1);
	assign mul_last = cnt_q == CW'(MB - 1);
	assign exp_done = (exp_q >> 1) == '0;

	assign red_next = modexp_pkg::mod_fold({1'b0, red_q, bmag_q[BB-1]}, mod_q);
	assign ra_next  = modexp_pkg::mod_fold({1'b0, ra_q, 1'b0}
		+ (mplr_q[MB-1] ? {2'b00, acc_q} : '0), mod_q);
	assign rs_next  = modexp_pkg::mod_fold({1'b0, rs_q, 1'b0}
		+ (mplr_q[MB-1] ? {2'b00, sq_q} : '0), mod_q);
	assign sq_start = (bneg_q && red_q != '0) ? mod_q - red_q : red_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = in_trivial ? modexp_pkg::ST_FINISH : modexp_pkg::ST_REDUCE;
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (red_last) begin
					state_d = modexp_pkg::ST_PREP;
				end
			end
			modexp_pkg::ST_PREP: begin
				state_d = (exp_q == '0) ? modexp_pkg::ST_FINISH : modexp_pkg::ST_MUL;
			end
			modexp_pkg::ST_MUL: begin
				if (mul_last && exp_done) begin
					state_d = modexp_pkg::ST_FINISH;
				end
			end
			modexp_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = modexp_pkg::ST_IDLE;
				end
			end
			default: state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			modexp_pkg::ST_IDLE:   s_axis_tready = 1'b1;
			modexp_pkg::ST_FINISH: out_load      = out_free;
			default: begin
				s_axis_tready = 1'b0;
				out_load      = 1'b0;
			end
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= modexp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept || (state_q == modexp_pkg::ST_PREP)
				|| (state_q == modexp_pkg::ST_MUL && mul_last)) begin
				cnt_q <= '0;
			end else if (state_q == modexp_pkg::ST_REDUCE || state_q == modexp_pkg::ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			mod_q  <= in_mod[MB-1:0];
			bneg_q <= in_base[BB-1];
			bmag_q <= in_base[BB-1] ? (~in_base + 1'b1) : in_base;
			exp_q  <= in_exp;
			red_q  <= '0;
			inv_q  <= in_bad;
			acc_q  <= '0;
		end
		unique case (state_q)
			modexp_pkg::ST_REDUCE: begin
				red_q  <= red_next;
				bmag_q <= bmag_q << 1;
			end
			modexp_pkg::ST_PREP: begin
				sq_q   <= sq_start;
				mplr_q <= sq_start;
				acc_q  <= MB'(1);
				ra_q   <= '0;
				rs_q   <= '0;
			end
			modexp_pkg::ST_MUL: begin
				if (mul_last) begin
					if (exp_q[0]) begin
						acc_q <= ra_next;
					end
					sq_q   <= rs_next;
					mplr_q <= rs_next;
					ra_q   <= '0;
					rs_q   <= '0;
					exp_q  <= exp_q >> 1;
				end else begin
					ra_q   <= ra_next;
					rs_q   <= rs_next;
					mplr_q <= mplr_q << 1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_res_q <= acc_q;
			out_inv_q <= inv_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OW'(out_res_q);
	assign m_axis_tuser  = out_inv_q;

	// invalid results carry a zero residue
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid result with non-zero residue");

	// operands and partial products stay reduced during multiplication
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == modexp_pkg::ST_MUL |-> acc_q < mod_q && sq_q < mod_q
			&& ra_q < mod_q && rs_q < mod_q)
		else $error("unreduced value in multiplier");

	// an accepted item starts work
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q != modexp_pkg::ST_IDLE)
		else $error("accepted item not started");

	// the result register is only loaded once free
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("result overwritten before taken");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for modular_exponentiation: directed and random items with a scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
	logic [modexp_pkg::MOD_BITS-1:0] residue;
	logic                            invalid;
} residue_t;

class residue_tracker;
	residue_t awaited[$];
	int       errors;

	function new();
		errors = 0;
	endfunction

	// right-to-left square-and-multiply; operands stay below 2^32 so 64-bit products are exact
	function residue_t expected_power(logic [63:0] b, logic [63:0] e, logic [32:0] m);
		residue_t    r;
		logic [63:0] m64;
		logic [63:0] sq;
		logic [63:0] acc;
		logic [63:0] rem;
		r.residue = '0;
		r.invalid = 1'b0;
		if (m[32] || m == '0 || e[63]) begin
			r.invalid = 1'b1;
			return r;
		end
		m64 = {31'd0, m};
		if (m64 == 64'd1) begin
			return r;
		end
		if (b[63]) begin
			rem = (64'd0 - b) % m64;
			sq  = (rem == 64'd0) ? 64'd0 : m64 - rem;
		end else begin
			sq = b % m64;
		end
		acc = 64'd1;
		for (int i = 0; i < 64; i++) begin
			if (e[i]) begin
				acc = (acc * sq) % m64;
			end
			sq = (sq * sq) % m64;
		end
		r.residue = acc[modexp_pkg::MOD_BITS-1:0];
		return r;
	endfunction

	function void note_operands(logic [63:0] b, logic [63:0] e, logic [32:0] m);
		awaited.push_back(expected_power(b, e, m));
	endfunction

	function void check_residue(logic [modexp_pkg::MOD_BITS-1:0] residue, logic invalid);
		residue_t want;
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: unexpected result item residue=%0d invalid=%0b", $time, residue,
				invalid);
			return;
		end
		want = awaited.pop_front();
		if (residue !== want.residue) begin
			errors++;
			$display("%0t: power_residue expected %0d got %0d", $time, want.residue, residue);
		end
		if (invalid !== want.invalid) begin
			errors++;
			$display("%0t: invalid expected %0b got %0b", $time, want.invalid, invalid);
		end
	endfunction

	function int outstanding();
		return awaited.size();
	endfunction
endclass

module tb_top;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 2200;
	localparam int RANDOM_ITEMS = 110;
	localparam logic [32:0] MOD_TOP = 33'h0_FFFF_FFFF;

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [modexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [modexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                               m_axis_tuser;

	residue_tracker tracker;
	logic           quiet;
	int             cycles;
	int             n;

	modular_exponentiation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				tracker.note_operands(s_axis_tdata[modexp_pkg::BASE_LSB +: 64],
					s_axis_tdata[modexp_pkg::EXP_LSB +: 64],
					s_axis_tdata[modexp_pkg::MOD_LSB +: modexp_pkg::MOD_BITS + 1]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				tracker.check_residue(m_axis_tdata[modexp_pkg::MOD_BITS-1:0], m_axis_tuser);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_operands(input logic [63:0] b, input logic [63:0] e,
		input logic [32:0] m);
		logic [modexp_pkg::IN_TDATA_W-1:0] word;
		int                                gap;
		word = '0;
		word[modexp_pkg::BASE_LSB +: 64] = b;
		word[modexp_pkg::EXP_LSB +: 64] = e;
		word[modexp_pkg::MOD_LSB +: modexp_pkg::MOD_BITS + 1] = m;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	task automatic random_operands();
		logic [63:0] b;
		logic [63:0] e;
		logic [31:0] mv;
		logic [32:0] m;
		int          w;
		case ($urandom_range(0, 3))
			0: mv = $urandom_range(2, 255);
			1: mv = 32'hFFFF_FFFF - $urandom_range(0, 1000);
			default: mv = $urandom;
		endcase
		if (mv == '0) begin
			mv = 32'd1;
		end
		if ($urandom_range(0, 30) == 0) begin
			mv = 32'd1;
		end
		m = {1'b0, mv};
		w = $urandom_range(0, 63);
		e = rand64() & ((64'd1 << w) - 64'd1);
		case ($urandom_range(0, 5))
			0: b = 64'($urandom_range(0, 300));
			1: b = 64'd0 - (64'($urandom_range(1, 1 << 30)) * {32'd0, mv});
			default: b = rand64();
		endcase
		// broken items: modulus not positive or exponent negative
		case ($urandom_range(0, 9))
			0: m = {1'b1, 32'($urandom)};
			1: m = '0;
			2: e = rand64() | 64'h8000_0000_0000_0000;
			default: ;
		endcase
		send_operands(b, e, m);
	endtask

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		quiet         = 1'b0;
		cycles        = 0;
		tracker       = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_operands(64'd2, 64'd10, 33'd1000);
		send_operands(64'd12345, 64'd0, 33'd7);
		send_operands(64'd0, 64'd0, 33'd5);
		send_operands(64'd0, 64'd5, 33'd5);
		send_operands(64'd99, 64'd77, 33'd1);
		send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 33'd1);
		send_operands(64'd3, 64'd4, 33'd0);
		send_operands(64'd3, 64'd4, 33'h1_FFFF_FFFB);
		send_operands(64'd3, 64'd4, 33'h1_0000_0000);
		send_operands(64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 33'd11);
		send_operands(64'd3, 64'h8000_0000_0000_0000, 33'd11);
		send_operands(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, MOD_TOP);
		send_operands(64'h8000_0000_0000_0000, 64'd3, MOD_TOP);
		send_operands(64'hFFFF_FFFF_FFFF_FFEB, 64'd5, 33'd7);
		send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'd3, MOD_TOP);
		send_operands(64'hFFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF, MOD_TOP);
		send_operands(64'd123456789, 64'd4294967290, 33'd4294967291);
		send_operands(64'd7, 64'h5555_5555_5555_5555, 33'd2);
		send_operands(64'hDEAD_BEEF_CAFE_F00D, 64'hAAAA_AAAA_AAAA_AAAA >> 1, 33'd65537);
		send_operands(64'd5, 64'd1, 33'd2);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 65) begin
				pause_until_drained();
			end
			quiet = (n >= 90 && n < 110);
			random_operands();
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
